[sv/gdo_pkg.sv]
`timescale 1ns / 1ps

package gdo_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int OFFSET_W = 17;
    localparam int ERR_W    = 2;

    localparam int MAX_OFFSET = 65535;
    localparam int COUNT_W    = $clog2(MAX_OFFSET + 1);

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = {YEAR_W{1'b1}};
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE = YEAR_W'(400);
    localparam logic [YEAR_W-1:0]  CYCLE_LAST = YEAR_W'(399);
    localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LAST   = DAY_W'(31);
    localparam logic [WDAY_W-1:0]  WDAY_FIRST = WDAY_W'(1);
    localparam logic [WDAY_W-1:0]  WDAY_LAST  = WDAY_W'(7);

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_CLEAR,
        OP_STEP,
        OP_LIMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fwd;
    } ctl_t;

    typedef struct packed {
        logic cycle_big;
        logic date_valid;
        logic at_limit;
    } status_t;

    // Length of a month; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            if (m == MONTH_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if (m < MONTH_JAN || m > MONTH_DEC)
            begin
                len = '0;
            end
            else
            begin
                len = MONTH_LEN[m - MONTH_JAN];
            end
            return len;
        end
    endfunction

endpackage

[sv/gdo_seq.sv]
`timescale 1ns / 1ps

module gdo_seq
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [16:0]             day_offset,
    input  gdo_pkg::status_t        status,
    output gdo_pkg::ctl_t           ctl,
    output logic                    busy,
    output logic                    done
);
    import gdo_pkg::*;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 fwd_reg, fwd_next;
    logic [OFFSET_W-1:0]  mag;
    logic [COUNT_W-1:0]   mag_sat;

    // Magnitude of the offset, saturated to the largest allowed step count.
    always_comb
    begin
        mag = day_offset[OFFSET_W-1] ? (~day_offset + OFFSET_W'(1)) : day_offset;
        if (mag > OFFSET_W'(MAX_OFFSET))
        begin
            mag_sat = COUNT_W'(MAX_OFFSET);
        end
        else
        begin
            mag_sat = mag[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fwd_next   = fwd_reg;
        ctl.op     = OP_NONE;
        ctl.fwd    = fwd_reg;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.op     = OP_LOAD;
                    count_next = mag_sat;
                    fwd_next   = !day_offset[OFFSET_W-1];
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.cycle_big)
                begin
                    ctl.op = OP_REDUCE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.date_valid)
                begin
                    ctl.op     = OP_CLEAR;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (status.at_limit)
                begin
                    ctl.op     = OP_LIMIT;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.op     = OP_STEP;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/gdo_dp.sv]
`timescale 1ns / 1ps

module gdo_dp
(
    input  logic              clk,
    input  gdo_pkg::ctl_t     ctl,
    input  logic [15:0]       start_year,
    input  logic [3:0]        start_month,
    input  logic [4:0]        start_day,
    input  logic [2:0]        start_weekday,
    output gdo_pkg::status_t  status,
    output logic [15:0]       end_year,
    output logic [3:0]        end_month,
    output logic [4:0]        end_day,
    output logic [2:0]        end_weekday,
    output logic [1:0]        error_code
);
    import gdo_pkg::*;

    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [WDAY_W-1:0]  wday_reg, wday_next;
    logic [YEAR_W-1:0]  cyc_reg, cyc_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               leap;
    logic [DAY_W-1:0]   dim;

    // cyc_reg holds the year modulo 400 once the reduction has finished.
    assign leap = (cyc_reg[1:0] == 2'b00) && (cyc_reg != YEAR_W'(100))
               && (cyc_reg != YEAR_W'(200)) && (cyc_reg != YEAR_W'(300));
    assign dim  = days_in(leap, month_reg);

    always_comb
    begin
        status.cycle_big  = (cyc_reg >= LEAP_CYCLE);
        status.date_valid = (day_reg >= DAY_FIRST) && (day_reg <= dim) && (dim != '0);
        if (ctl.fwd)
        begin
            status.at_limit = (year_reg == YEAR_MAX) && (month_reg == MONTH_DEC)
                           && (day_reg == DAY_LAST);
        end
        else
        begin
            status.at_limit = (year_reg == '0) && (month_reg == MONTH_JAN)
                           && (day_reg == DAY_FIRST);
        end
    end

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        wday_next  = wday_reg;
        cyc_next   = cyc_reg;
        err_next   = err_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                year_next  = start_year;
                month_next = start_month;
                day_next   = start_day;
                wday_next  = start_weekday;
                cyc_next   = start_year;
                err_next   = ERR_OK;
            end
            OP_REDUCE:
            begin
                cyc_next = cyc_reg - LEAP_CYCLE;
            end
            OP_CLEAR:
            begin
                year_next  = '0;
                month_next = '0;
                day_next   = '0;
                wday_next  = '0;
                err_next   = ERR_INVALID;
            end
            OP_LIMIT:
            begin
                err_next = ERR_RANGE;
            end
            OP_STEP:
            begin
                if (ctl.fwd)
                begin
                    wday_next = (wday_reg >= WDAY_LAST) ? WDAY_FIRST
                                                        : wday_reg + WDAY_W'(1);
                    if (day_reg >= dim)
                    begin
                        day_next = DAY_FIRST;
                        if (month_reg >= MONTH_DEC)
                        begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + YEAR_W'(1);
                            cyc_next   = (cyc_reg == CYCLE_LAST) ? '0
                                                                 : cyc_reg + YEAR_W'(1);
                        end
                        else
                        begin
                            month_next = month_reg + MONTH_W'(1);
                        end
                    end
                    else
                    begin
                        day_next = day_reg + DAY_W'(1);
                    end
                end
                else
                begin
                    wday_next = (wday_reg <= WDAY_FIRST) ? WDAY_LAST
                                                         : wday_reg - WDAY_W'(1);
                    if (day_reg <= DAY_FIRST)
                    begin
                        if (month_reg <= MONTH_JAN)
                        begin
                            // December always has 31 days, so the new year's
                            // leap status does not matter here.
                            month_next = MONTH_DEC;
                            day_next   = DAY_LAST;
                            year_next  = year_reg - YEAR_W'(1);
                            cyc_next   = (cyc_reg == '0) ? CYCLE_LAST
                                                         : cyc_reg - YEAR_W'(1);
                        end
                        else
                        begin
                            month_next = month_reg - MONTH_W'(1);
                            day_next   = days_in(leap, month_reg - MONTH_W'(1));
                        end
                    end
                    else
                    begin
                        day_next = day_reg - DAY_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        wday_reg  <= wday_next;
        cyc_reg   <= cyc_next;
        err_reg   <= err_next;
    end

    assign end_year    = year_reg;
    assign end_month   = month_reg;
    assign end_day     = day_reg;
    assign end_weekday = wday_reg;
    assign error_code  = err_reg;

endmodule

[sv/gregorian_date_offset.sv]
`timescale 1ns / 1ps

// Gregorian date stepper: adds a signed day offset to a date and weekday.
// A request is taken at a rising clock edge where start is high and busy is
// low; start_year, start_month, start_day, start_weekday and day_offset are
// sampled at that edge. busy then stays high until the result is delivered.
// The result (end_year, end_month, end_day, end_weekday, error_code) is valid
// for exactly one cycle while done is high; the receiver cannot stall it, and
// the ports keep showing the last result afterward.
// Sequence: the year is first reduced modulo 400 by repeated subtraction, one
// subtraction per cycle, then the start date is checked, then the date moves
// one day per cycle for |day_offset| days, at most 65535. The step loop, one
// day per cycle, dominates the time an item takes. An invalid start date
// skips the stepping; hitting the year limits ends it early.
// One request is in flight at a time. Reset returns the sequencer to idle
// with busy and done low; no result is pending after reset.
module gregorian_date_offset
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] start_year,
    input  logic [3:0]  start_month,
    input  logic [4:0]  start_day,
    input  logic [2:0]  start_weekday,
    input  logic [16:0] day_offset,
    output logic        done,
    output logic [15:0] end_year,
    output logic [3:0]  end_month,
    output logic [4:0]  end_day,
    output logic [2:0]  end_weekday,
    output logic [1:0]  error_code
);
    import gdo_pkg::*;

    ctl_t    ctl;
    status_t status;

    // The sequencer owns the step count and direction and drives one
    // operation per cycle into the date datapath.
    gdo_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .day_offset (day_offset),
        .status     (status),
        .ctl        (ctl),
        .busy       (busy),
        .done       (done)
    );

    // The datapath holds the running date, weekday and year modulo 400, and
    // its registers drive the result ports directly.
    gdo_dp u_dp
    (
        .clk           (clk),
        .ctl           (ctl),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .start_weekday (start_weekday),
        .status        (status),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .end_weekday   (end_weekday),
        .error_code    (error_code)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

typedef struct packed {
    logic [gdo_pkg::YEAR_W-1:0]   year;
    logic [gdo_pkg::MONTH_W-1:0]  month;
    logic [gdo_pkg::DAY_W-1:0]    day;
    logic [gdo_pkg::WDAY_W-1:0]   wday;
    logic [gdo_pkg::OFFSET_W-1:0] offset;
} date_request_t;

typedef struct packed {
    logic [gdo_pkg::YEAR_W-1:0]  year;
    logic [gdo_pkg::MONTH_W-1:0] month;
    logic [gdo_pkg::DAY_W-1:0]   day;
    logic [gdo_pkg::WDAY_W-1:0]  wday;
    logic [gdo_pkg::ERR_W-1:0]   err;
} date_result_t;

// Gregorian rule: every fourth year, except centuries not divisible by 400.
function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
endfunction

function automatic int days_in_month(input int y, input int m);
    int len;
    begin
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    end
endfunction

class date_scoreboard;
    date_result_t expected_dates[$];
    int unsigned  failures;

    function new();
        failures = 0;
    endfunction

    // Walks the date one day at a time, as the hardware does, and stops at
    // the edges of the year range.
    function date_result_t shift_date(input date_request_t req);
        date_result_t res;
        int y, m, d, w, off, steps;
        bit fwd;
        begin
            y   = req.year;
            m   = req.month;
            d   = req.day;
            w   = req.wday;
            off = $signed(req.offset);
            if (off > gdo_pkg::MAX_OFFSET)
            begin
                off = gdo_pkg::MAX_OFFSET;
            end
            if (off < -gdo_pkg::MAX_OFFSET)
            begin
                off = -gdo_pkg::MAX_OFFSET;
            end
            fwd   = off > 0;
            steps = fwd ? off : -off;
            res   = '0;
            if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m))
            begin
                res.err = gdo_pkg::ERR_INVALID;
                return res;
            end
            res.err = gdo_pkg::ERR_OK;
            while (steps != 0)
            begin
                if (fwd)
                begin
                    if (y == 65535 && m == 12 && d == 31)
                    begin
                        res.err = gdo_pkg::ERR_RANGE;
                        break;
                    end
                    d++;
                    w = (w >= 7) ? 1 : w + 1;
                    if (d > days_in_month(y, m))
                    begin
                        d = 1;
                        m++;
                        if (m > 12)
                        begin
                            m = 1;
                            y++;
                        end
                    end
                end
                else
                begin
                    if (y == 0 && m == 1 && d == 1)
                    begin
                        res.err = gdo_pkg::ERR_RANGE;
                        break;
                    end
                    w = (w <= 1) ? 7 : w - 1;
                    if (d <= 1)
                    begin
                        m--;
                        if (m < 1)
                        begin
                            m = 12;
                            y--;
                        end
                        d = days_in_month(y, m);
                    end
                    else
                    begin
                        d--;
                    end
                end
                steps--;
            end
            res.year  = y[15:0];
            res.month = m[3:0];
            res.day   = d[4:0];
            res.wday  = w[2:0];
            return res;
        end
    endfunction

    function void note_request(input date_request_t req);
        expected_dates.push_back(shift_date(req));
    endfunction

    function void check_result(input date_result_t got);
        date_result_t want;
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            want = expected_dates.pop_front();
            if (got.year !== want.year)
            begin
                $error("end_year: expected %0d, got %0d", want.year, got.year);
                failures++;
            end
            if (got.month !== want.month)
            begin
                $error("end_month: expected %0d, got %0d", want.month, got.month);
                failures++;
            end
            if (got.day !== want.day)
            begin
                $error("end_day: expected %0d, got %0d", want.day, got.day);
                failures++;
            end
            if (got.wday !== want.wday)
            begin
                $error("end_weekday: expected %0d, got %0d", want.wday, got.wday);
                failures++;
            end
            if (got.err !== want.err)
            begin
                $error("error_code: expected %0d, got %0d", want.err, got.err);
                failures++;
            end
        end
    endfunction

    function int unsigned outstanding();
        return expected_dates.size();
    endfunction
endclass

module tb_top;

    // A single request can keep the block busy for the year reduction plus
    // up to 65535 day steps. The watchdog allows several times that long
    // with no request or result accepted before it gives up.
    localparam int unsigned STALL_LIMIT  = 280000;
    localparam int          RANDOM_COUNT = 100;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [2:0]  start_weekday;
    logic [16:0] day_offset;
    logic        done;
    logic [15:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [2:0]  end_weekday;
    logic [1:0]  error_code;

    date_scoreboard ledger;
    int unsigned    idle_cycles;

    gregorian_date_offset dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .start_weekday (start_weekday),
        .day_offset    (day_offset),
        .done          (done),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .end_weekday   (end_weekday),
        .error_code    (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Packs a request; the offset is given as a plain integer and truncated
    // to the 17-bit port, so -65536 becomes the lone out-of-range code.
    function automatic date_request_t date_request(input int y, input int m,
                                                   input int d, input int w,
                                                   input int off);
        date_request_t req;
        begin
            req.year   = y[15:0];
            req.month  = m[3:0];
            req.day    = d[4:0];
            req.wday   = w[2:0];
            req.offset = off[16:0];
            return req;
        end
    endfunction

    // Drives one request after an idle gap of the given number of cycles.
    // Inputs change only at falling edges; busy is sampled at the rising
    // edge, so the request is taken at the first edge where busy was low.
    // With no gap, start simply stays high from the previous request.
    task automatic issue_request(input date_request_t req, input int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start         <= 1'b1;
        start_year    <= req.year;
        start_month   <= req.month;
        start_day     <= req.day;
        start_weekday <= req.wday;
        day_offset    <= req.offset;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        ledger.note_request(req);
    endtask

    // Done is high for one cycle only, so every done cycle is checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            ledger.check_result({end_year, end_month, end_day, end_weekday, error_code});
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result moved.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int kind, y, m, d, w, off;
        int unsigned gap, burst_left;

        ledger        = new();
        rst_n         = 1'b0;
        start         = 1'b0;
        start_year    = '0;
        start_month   = '0;
        start_day     = '0;
        start_weekday = '0;
        day_offset    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests, issued back to back with no idle cycles.
        // Leap-day handling around February in normal, century and 400 years, then a year rollover.
        issue_request(date_request(2024, 2, 28, 3, 1), 0);
        issue_request(date_request(2023, 2, 28, 3, 1), 0);
        issue_request(date_request(2100, 3, 1, 2, -1), 0);
        issue_request(date_request(2400, 2, 28, 5, 1), 0);
        issue_request(date_request(2099, 12, 31, 7, 1), 0);
        // Zero offset leaves a valid date alone, including a leap day.
        issue_request(date_request(2000, 2, 29, 4, 0), 0);
        // Invalid start dates: a non-leap February 29th, month zero, months
        // beyond December, day zero, and a 31st in a 30-day month. The
        // large offset shows that stepping is skipped entirely.
        issue_request(date_request(1900, 2, 29, 1, 5), 0);
        issue_request(date_request(2020, 0, 1, 1, 65535), 0);
        issue_request(date_request(2020, 13, 10, 2, 1), 0);
        issue_request(date_request(65535, 15, 31, 7, -65536), 0);
        issue_request(date_request(2020, 6, 0, 2, 1), 0);
        issue_request(date_request(2020, 4, 31, 2, 1), 0);
        // Weekday zero passes through a zero offset, moves to 1 on a forward step and to 7 on a backward one;
        // the valid weekdays wrap between 7 and 1.
        issue_request(date_request(2020, 1, 31, 0, 0), 0);
        issue_request(date_request(2020, 1, 31, 0, 1), 0);
        issue_request(date_request(2020, 1, 31, 0, -1), 0);
        issue_request(date_request(2020, 5, 15, 7, 1), 0);
        issue_request(date_request(2020, 5, 15, 1, -1), 0);
        // Year range limits: stepping stops at the first or last date and flags it.
        // Year 0 is a leap year, so its February 29th is a valid start.
        issue_request(date_request(65535, 12, 31, 7, 1), 0);
        issue_request(date_request(65535, 12, 20, 3, 65535), 0);
        issue_request(date_request(0, 2, 29, 1, -60), 0);
        issue_request(date_request(0, 1, 1, 6, -1), 0);
        issue_request(date_request(0, 1, 1, 6, -65536), 0);
        // Full-length walks: the largest offset, and the one below the limit
        // that saturates to the largest negative offset.
        issue_request(date_request(2000, 1, 1, 6, 65535), 0);
        issue_request(date_request(1990, 6, 15, 5, -65536), 0);

        // Random requests in bursts separated by random gaps. Most are valid
        // dates with short offsets so the walk stays cheap; some sit at the
        // ends of the year range, some are raw noise, and a few use the
        // whole offset range.
        burst_left = 0;
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            else
            begin
                gap = 0;
            end
            burst_left--;

            kind = $urandom_range(0, 19);
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 7);
            off = $urandom_range(0, 1500);
            if ($urandom_range(0, 1) == 1)
            begin
                off = -off;
            end
            if (kind < 12)
            begin
                // Years spread over the range, or close to a century.
                if ($urandom_range(0, 1) == 0)
                begin
                    y = $urandom_range(0, 65535);
                end
                else
                begin
                    y = $urandom_range(0, 655) * 100 + $urandom_range(0, 4);
                end
                m = $urandom_range(1, 12);
                d = $urandom_range(1, days_in_month(y, m));
            end
            else if (kind < 15)
            begin
                y = 65535 - $urandom_range(0, 1);
                m = 12 - $urandom_range(0, 1);
                d = $urandom_range(1, days_in_month(y, m));
                off = int'($urandom_range(0, 800));
                if ($urandom_range(0, 3) == 0)
                begin
                    off = -off;
                end
            end
            else if (kind < 18)
            begin
                y = $urandom_range(0, 1);
                m = $urandom_range(1, 2);
                d = $urandom_range(1, days_in_month(y, m));
                off = -int'($urandom_range(0, 800));
                if ($urandom_range(0, 3) == 0)
                begin
                    off = -off;
                end
            end
            else if (kind == 18)
            begin
                y = $urandom_range(0, 65535);
                m = $urandom_range(0, 15);
                d = $urandom_range(0, 31);
            end
            else
            begin
                y = $urandom_range(0, 65535);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, days_in_month(y, m));
                off = int'($urandom_range(0, 131071)) - 65536;
            end
            issue_request(date_request(y, m, d, w, off), gap);
        end

        @(negedge clk);
        start <= 1'b0;

        // Every request yields exactly one result, so once the store of
        // expected dates is empty only a short settle window remains.
        while (ledger.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (ledger.failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
